// ----- src/cfhp_pkg.sv -----
// Types, codes and helpers shared by the class file header parser.
`timescale 1ns / 1ps
`default_nettype none
package cfhp_pkg;

  localparam logic [31:0] MAGIC_WORD = 32'hCAFEBABE;

  // parse phases
  localparam logic [3:0] PH_MAGIC     = 4'd0;
  localparam logic [3:0] PH_MINOR     = 4'd1;
  localparam logic [3:0] PH_MAJOR     = 4'd2;
  localparam logic [3:0] PH_POOLCOUNT = 4'd3;
  localparam logic [3:0] PH_TAG       = 4'd4;
  localparam logic [3:0] PH_OPER1     = 4'd5;
  localparam logic [3:0] PH_OPER2     = 4'd6;
  localparam logic [3:0] PH_FLAGS     = 4'd7;
  localparam logic [3:0] PH_THIS      = 4'd8;
  localparam logic [3:0] PH_SUPER     = 4'd9;
  localparam logic [3:0] PH_IFCOUNT   = 4'd10;
  localparam logic [3:0] PH_IFACE     = 4'd11;
  localparam logic [3:0] PH_IDLE      = 4'd12;

  // record kinds
  localparam logic [3:0] K_MINOR     = 4'd0;
  localparam logic [3:0] K_MAJOR     = 4'd1;
  localparam logic [3:0] K_POOLCOUNT = 4'd2;
  localparam logic [3:0] K_ENTRY     = 4'd3;
  localparam logic [3:0] K_FLAGS     = 4'd4;
  localparam logic [3:0] K_THIS      = 4'd5;
  localparam logic [3:0] K_SUPER     = 4'd6;
  localparam logic [3:0] K_IFCOUNT   = 4'd7;
  localparam logic [3:0] K_IFACE     = 4'd8;
  localparam logic [3:0] K_DONE      = 4'd9;
  localparam logic [3:0] K_ERROR     = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SHORT = 2'd1;
  localparam logic [1:0] ERR_MAGIC = 2'd2;
  localparam logic [1:0] ERR_TAG   = 2'd3;

  // constant pool tags
  localparam logic [7:0] TAG_INTEGER    = 8'd3;
  localparam logic [7:0] TAG_FLOAT      = 8'd4;
  localparam logic [7:0] TAG_LONG       = 8'd5;
  localparam logic [7:0] TAG_DOUBLE     = 8'd6;
  localparam logic [7:0] TAG_CLASS      = 8'd7;
  localparam logic [7:0] TAG_STRING     = 8'd8;
  localparam logic [7:0] TAG_FIELDREF   = 8'd9;
  localparam logic [7:0] TAG_METHODREF  = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF = 8'd11;
  localparam logic [7:0] TAG_NAMETYPE   = 8'd12;
  localparam logic [7:0] TAG_MHANDLE    = 8'd15;
  localparam logic [7:0] TAG_MTYPE      = 8'd16;
  localparam logic [7:0] TAG_DYNAMIC    = 8'd17;
  localparam logic [7:0] TAG_INVDYN     = 8'd18;
  localparam logic [7:0] TAG_MODULE     = 8'd19;
  localparam logic [7:0] TAG_PACKAGE    = 8'd20;

  // output queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QLW    = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [7:0]  entry_tag;
    logic [15:0] entry_index;
    logic [31:0] value_first;
    logic [31:0] value_second;
    logic [1:0]  error_code;
    logic        last_of_file;
  } rec_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  nbytes;
    logic [31:0] acc;
    logic [31:0] first_op;
    logic [7:0]  tag;
    logic [15:0] slots_left;
    logic [15:0] slot_num;
    logic [15:0] if_left;
    logic [15:0] if_num;
  } state_t;

  typedef struct packed {
    logic [1:0] n;
    rec_t       first;
    rec_t       second;
  } push_t;

  typedef struct packed {
    logic [QLW-1:0] level;
    logic           room;
  } qstat_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] w1;
    logic [2:0] w2;
  } tagw_t;

  // parser state after reset: expecting the magic word, everything else clear
  function automatic state_t rearm_state();
    state_t s;
    s = '0;
    s.phase = PH_MAGIC;
    return s;
  endfunction

  function automatic tagw_t tag_info(input logic [7:0] tag);
    tagw_t t;
    t = '0;
    unique case (tag)
      TAG_CLASS, TAG_STRING, TAG_MTYPE, TAG_MODULE, TAG_PACKAGE: begin
        t.ok = 1'b1; t.w1 = 3'd2;
      end
      TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMETYPE,
      TAG_DYNAMIC, TAG_INVDYN: begin
        t.ok = 1'b1; t.w1 = 3'd2; t.w2 = 3'd2;
      end
      TAG_INTEGER, TAG_FLOAT: begin
        t.ok = 1'b1; t.w1 = 3'd4;
      end
      TAG_LONG, TAG_DOUBLE: begin
        t.ok = 1'b1; t.w1 = 3'd4; t.w2 = 3'd4;
      end
      TAG_MHANDLE: begin
        t.ok = 1'b1; t.w1 = 3'd1; t.w2 = 3'd2;
      end
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic rec_t make_rec(input logic [3:0] kind, input logic [7:0] tag,
                                    input logic [15:0] idx, input logic [31:0] v1,
                                    input logic [31:0] v2, input logic [1:0] err);
    rec_t r;
    r.record_kind  = kind;
    r.entry_tag    = tag;
    r.entry_index  = idx;
    r.value_first  = v1;
    r.value_second = v2;
    r.error_code   = err;
    r.last_of_file = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/cfhp_step.sv -----
// Parser step: next state and up to two records for one input byte.
`timescale 1ns / 1ps
`default_nettype none
module cfhp_step import cfhp_pkg::*; (
  input  var state_t st,
  input  var item_t  item,
  output state_t     st_next,
  output push_t      push
);

  logic [31:0] acc;
  logic [2:0]  cnt;
  logic [2:0]  width;
  tagw_t       tw;
  tagw_t       tw_cur;
  logic [15:0] step_n;
  logic [15:0] left_n;
  logic [15:0] ifl_n;
  rec_t        ra;
  logic        has_a;
  logic        has_done;
  logic        ended;
  state_t      nx;
  rec_t        o0;
  rec_t        o1;
  logic [1:0]  n;

  assign acc    = {st.acc[23:0], item.data_byte};
  assign cnt    = st.nbytes + 3'd1;
  assign tw_cur = tag_info(st.tag);
  assign tw     = tag_info(acc[7:0]);
  assign step_n = (st.tag == TAG_LONG || st.tag == TAG_DOUBLE) ? 16'd2 : 16'd1;
  assign left_n = (st.slots_left > step_n) ? st.slots_left - step_n : 16'd0;
  assign ifl_n  = st.if_left - 16'd1;

  always_comb begin
    unique case (st.phase)
      PH_MAGIC: width = 3'd4;
      PH_TAG:   width = 3'd1;
      PH_OPER1: width = (tw_cur.w1 != 3'd0) ? tw_cur.w1 : 3'd1;
      PH_OPER2: width = (tw_cur.w2 != 3'd0) ? tw_cur.w2 : 3'd1;
      default:  width = 3'd2;
    endcase
  end

  always_comb begin
    nx       = st;
    ra       = '0;
    has_a    = 1'b0;
    has_done = 1'b0;
    ended    = 1'b0;
    if (st.phase != PH_IDLE) begin
      if (cnt >= width) begin
        nx.nbytes = 3'd0;
        nx.acc    = 32'd0;
        unique case (st.phase)
          PH_MAGIC: begin
            if (acc != MAGIC_WORD) begin
              ra = make_rec(K_ERROR, 8'd0, 16'd0, 32'd0, 32'd0, ERR_MAGIC);
              has_a = 1'b1; ended = 1'b1; nx.phase = PH_IDLE;
            end else begin
              nx.phase = PH_MINOR;
            end
          end
          PH_MINOR: begin
            ra = make_rec(K_MINOR, 8'd0, 16'd0, acc, 32'd0, ERR_NONE);
            has_a = 1'b1; nx.phase = PH_MAJOR;
          end
          PH_MAJOR: begin
            ra = make_rec(K_MAJOR, 8'd0, 16'd0, acc, 32'd0, ERR_NONE);
            has_a = 1'b1; nx.phase = PH_POOLCOUNT;
          end
          PH_POOLCOUNT: begin
            ra = make_rec(K_POOLCOUNT, 8'd0, 16'd0, acc, 32'd0, ERR_NONE);
            has_a = 1'b1;
            nx.slots_left = (acc[15:0] != 16'd0) ? acc[15:0] - 16'd1 : 16'd0;
            nx.slot_num   = 16'd1;
            nx.phase      = (acc[15:0] > 16'd1) ? PH_TAG : PH_FLAGS;
          end
          PH_TAG: begin
            nx.tag = acc[7:0];
            if (!tw.ok) begin
              ra = make_rec(K_ERROR, 8'd0, 16'd0, 32'd0, 32'd0, ERR_TAG);
              has_a = 1'b1; ended = 1'b1; nx.phase = PH_IDLE;
            end else begin
              nx.phase = PH_OPER1;
            end
          end
          PH_OPER1: begin
            if (tw_cur.w2 == 3'd0) begin
              ra = make_rec(K_ENTRY, st.tag, st.slot_num, acc, 32'd0, ERR_NONE);
              has_a = 1'b1;
              nx.slots_left = left_n;
              nx.slot_num   = st.slot_num + step_n;
              nx.phase      = (left_n != 16'd0) ? PH_TAG : PH_FLAGS;
            end else begin
              nx.first_op = acc;
              nx.phase    = PH_OPER2;
            end
          end
          PH_OPER2: begin
            ra = make_rec(K_ENTRY, st.tag, st.slot_num, st.first_op, acc, ERR_NONE);
            has_a = 1'b1;
            nx.slots_left = left_n;
            nx.slot_num   = st.slot_num + step_n;
            nx.phase      = (left_n != 16'd0) ? PH_TAG : PH_FLAGS;
          end
          PH_FLAGS: begin
            ra = make_rec(K_FLAGS, 8'd0, 16'd0, acc, 32'd0, ERR_NONE);
            has_a = 1'b1; nx.phase = PH_THIS;
          end
          PH_THIS: begin
            ra = make_rec(K_THIS, 8'd0, 16'd0, acc, 32'd0, ERR_NONE);
            has_a = 1'b1; nx.phase = PH_SUPER;
          end
          PH_SUPER: begin
            ra = make_rec(K_SUPER, 8'd0, 16'd0, acc, 32'd0, ERR_NONE);
            has_a = 1'b1; nx.phase = PH_IFCOUNT;
          end
          PH_IFCOUNT: begin
            ra = make_rec(K_IFCOUNT, 8'd0, 16'd0, acc, 32'd0, ERR_NONE);
            has_a = 1'b1;
            nx.if_left = acc[15:0];
            nx.if_num  = 16'd0;
            if (acc[15:0] == 16'd0) begin
              has_done = 1'b1; ended = 1'b1; nx.phase = PH_IDLE;
            end else begin
              nx.phase = PH_IFACE;
            end
          end
          PH_IFACE: begin
            ra = make_rec(K_IFACE, 8'd0, st.if_num, acc, 32'd0, ERR_NONE);
            has_a = 1'b1;
            nx.if_num  = st.if_num + 16'd1;
            nx.if_left = ifl_n;
            if (ifl_n == 16'd0) begin
              has_done = 1'b1; ended = 1'b1; nx.phase = PH_IDLE;
            end
          end
          default: nx = st;
        endcase
      end else begin
        nx.acc    = acc;
        nx.nbytes = cnt;
      end
    end
  end

  // order the records and close the file on end_of_file
  always_comb begin
    o0 = '0;
    o1 = '0;
    n  = 2'd0;
    if (has_a) begin
      o0 = ra;
      n  = 2'd1;
    end
    if (has_done) begin
      o1 = make_rec(K_DONE, 8'd0, 16'd0, 32'd0, 32'd0, ERR_NONE);
      n  = 2'd2;
    end
    st_next = nx;
    if (item.end_of_file) begin
      if (ended) begin
        if (n == 2'd2) o1.last_of_file = 1'b1;
        else o0.last_of_file = 1'b1;
      end else if (nx.phase != PH_IDLE) begin
        if (n == 2'd0) begin
          o0 = make_rec(K_ERROR, 8'd0, 16'd0, 32'd0, 32'd0, ERR_SHORT);
          o0.last_of_file = 1'b1;
        end else begin
          o1 = make_rec(K_ERROR, 8'd0, 16'd0, 32'd0, 32'd0, ERR_SHORT);
          o1.last_of_file = 1'b1;
        end
        n = n + 2'd1;
      end
      st_next = '0;
      st_next.phase = PH_MAGIC;
    end
    push.n      = n;
    push.first  = o0;
    push.second = o1;
  end

endmodule
`default_nettype wire

// ----- src/cfhp_outq.sv -----
// Output record queue: takes up to two records a cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none
module cfhp_outq import cfhp_pkg::*; (
  input  var logic  clk,
  input  var logic  rst,
  input  var logic  wr_en,
  input  var push_t push,
  input  var logic  rd_en,
  output rec_t      rd_data,
  output qstat_t    stat
);

  rec_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QLW-1:0] level;
  logic [1:0]     n_eff;

  assign n_eff = wr_en ? push.n : 2'd0;

  always_ff @(posedge clk) begin
    if (n_eff != 2'd0) mem[wr_ptr] <= push.first;
    if (n_eff == 2'd2) mem[wr_ptr + QAW'(1)] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(n_eff);
      if (rd_en) rd_ptr <= rd_ptr + QAW'(1);
      level <= level + QLW'(n_eff) - QLW'(rd_en);
    end
  end

  assign rd_data    = mem[rd_ptr];
  assign stat.level = level;
  assign stat.room  = (level <= QLW'(QDEPTH - 2));

endmodule
`default_nettype wire

// ----- src/class_file_header_parser.sv -----
// Top level of the streaming class file header parser.
// A record enters the record queue when the byte that completes it is taken.
// Throughput: one byte per cycle while the queue has room (item_stall low); a
// byte that yields two records has both absorbed by a four-entry record queue.
// Reset: parser returns to expecting the magic word and the queue empties;
// end_of_file rearms the parser the same way after its byte.
`timescale 1ns / 1ps
`default_nettype none
module class_file_header_parser import cfhp_pkg::*; (
  input  var logic  clk,
  input  var logic  rst,
  input  var logic  item_valid,
  output logic      item_stall,
  input  var item_t item,
  output logic      record_valid,
  input  var logic  record_stall,
  output rec_t      record
);

  state_t st;
  state_t st_next;
  push_t  push;
  qstat_t qstat;
  logic   accept;
  logic   pop;

  assign item_stall   = !qstat.room;
  assign accept       = item_valid && !item_stall;
  assign record_valid = (qstat.level != '0);
  assign pop          = record_valid && !record_stall;

  cfhp_step u_step (
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .push    (push)
  );

  cfhp_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .push    (push),
    .rd_en   (pop),
    .rd_data (record),
    .stat    (qstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= rearm_state();
    end else if (accept) begin
      st <= st_next;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.level <= QLW'(QDEPTH))
    else $error("record queue overfilled");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    accept && st.phase == PH_IDLE && !item.end_of_file |-> push.n == 2'd0)
    else $error("record produced while parser idle");

  a_eof_rearm: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_file |=> st.phase == PH_MAGIC && st.nbytes == 3'd0)
    else $error("parser not rearmed after end of file");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !qstat.room |-> !accept)
    else $error("request taken without queue room");

endmodule
`default_nettype wire
